// File: sv/url_percent_decoder_macros.svh
// Assertion macros shared by the checker files of the URL percent decoder.
// Depends on nothing; include by bare file name.
`ifndef URL_PERCENT_DECODER_MACROS_SVH
`define URL_PERCENT_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("url_percent_decoder: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UPD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("url_percent_decoder: next-cycle check failed");

`endif

// File: sv/upd_pkg.sv
// Package for the URL percent decoder: result and command types, character
// constants and the small decode functions. Depends on nothing.
package upd_pkg;

    localparam int unsigned CMD_DEPTH = 4;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [4:0] LETTER_ADJ = 5'd9;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       last;
    } res_t;

    // Up to three results caused by one input byte, oldest in res[0].
    typedef struct packed {
        logic [1:0]     count;
        res_t [2:0]     res;
    } cmd_t;

    localparam res_t RES_NONE   = '{data: CH_NUL, has_byte: 1'b0, last: 1'b0};
    localparam res_t RES_MARKER = '{data: CH_NUL, has_byte: 1'b0, last: 1'b1};

    function automatic res_t char_res(input logic [7:0] b);
        char_res = '{data: b, has_byte: 1'b1, last: 1'b0};
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        is_blank = (b inside {[8'h09:8'h0D], CH_SPACE});
    endfunction

    // Low nibble, plus nine for 0x3A..0x7F (bytes above '9' as a signed char).
    function automatic logic [4:0] digit_value(input logic [7:0] b);
        logic [4:0] v;
        v = {1'b0, b[3:0]};
        if (b > CH_NINE && !b[7])
            v = v + LETTER_ADJ;
        digit_value = v;
    endfunction

    function automatic logic [7:0] decode_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic [4:0] h;
        logic [4:0] l;
        h = digit_value(hi);
        l = digit_value(lo);
        decode_pair = {h[3:0], 4'h0} + {3'b000, l};
    endfunction

endpackage

// File: sv/upd_front.sv
// Front end of the URL percent decoder: tracks escape and string state and
// turns each accepted byte into a command of up to three results. Uses upd_pkg.
module upd_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    in_byte,
    output logic          cmd_push,
    output upd_pkg::cmd_t cmd
);

    upd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]      first_reg, first_next;
    logic            seen_reg, seen_next;
    logic            discard_reg, discard_next;
    logic            is_nul;

    assign is_nul = (in_byte == upd_pkg::CH_NUL);

    // Next state.
    always_comb
    begin
        phase_next   = phase_reg;
        first_next   = first_reg;
        seen_next    = seen_reg;
        discard_next = discard_reg;
        if (accept)
        begin
            if (discard_reg)
            begin
                if (is_nul)
                begin
                    discard_next = 1'b0;
                    seen_next    = 1'b0;
                    phase_next   = upd_pkg::PH_IDLE;
                end
            end
            else
            begin
                case (phase_reg)
                    upd_pkg::PH_PCT:
                    begin
                        if (is_nul)
                        begin
                            phase_next = upd_pkg::PH_IDLE;
                            seen_next  = 1'b0;
                        end
                        else
                        begin
                            first_next = in_byte;
                            phase_next = upd_pkg::PH_DIGIT;
                        end
                    end
                    upd_pkg::PH_DIGIT:
                    begin
                        phase_next = upd_pkg::PH_IDLE;
                        if (is_nul)
                            seen_next = 1'b0;
                    end
                    default:
                    begin
                        phase_next = upd_pkg::PH_IDLE;
                        if (is_nul)
                            seen_next = 1'b0;
                        else if (upd_pkg::is_blank(in_byte))
                        begin
                            seen_next    = 1'b0;
                            discard_next = 1'b1;
                        end
                        else if (in_byte == upd_pkg::CH_PERCENT)
                        begin
                            seen_next  = 1'b1;
                            phase_next = upd_pkg::PH_PCT;
                        end
                    end
                endcase
            end
        end
    end

    // Results caused by the current byte.
    always_comb
    begin
        cmd.count  = 2'd0;
        cmd.res[0] = upd_pkg::RES_NONE;
        cmd.res[1] = upd_pkg::RES_NONE;
        cmd.res[2] = upd_pkg::RES_NONE;
        if (!discard_reg)
        begin
            case (phase_reg)
                upd_pkg::PH_PCT:
                begin
                    if (is_nul)
                    begin
                        cmd.count  = 2'd2;
                        cmd.res[0] = upd_pkg::char_res(upd_pkg::CH_PERCENT);
                        cmd.res[1] = upd_pkg::RES_MARKER;
                    end
                end
                upd_pkg::PH_DIGIT:
                begin
                    if (!is_nul)
                    begin
                        cmd.count  = 2'd1;
                        cmd.res[0] = upd_pkg::char_res(upd_pkg::decode_pair(first_reg, in_byte));
                    end
                    else if (upd_pkg::is_blank(first_reg))
                    begin
                        cmd.count  = 2'd2;
                        cmd.res[0] = upd_pkg::char_res(upd_pkg::CH_PERCENT);
                        cmd.res[1] = upd_pkg::RES_MARKER;
                    end
                    else
                    begin
                        cmd.count  = 2'd3;
                        cmd.res[0] = upd_pkg::char_res(upd_pkg::CH_PERCENT);
                        if (first_reg == upd_pkg::CH_PLUS && seen_reg)
                            cmd.res[1] = upd_pkg::char_res(upd_pkg::CH_SPACE);
                        else
                            cmd.res[1] = upd_pkg::char_res(first_reg);
                        cmd.res[2] = upd_pkg::RES_MARKER;
                    end
                end
                default:
                begin
                    if (is_nul || upd_pkg::is_blank(in_byte))
                    begin
                        cmd.count  = 2'd1;
                        cmd.res[0] = upd_pkg::RES_MARKER;
                    end
                    else if (in_byte == upd_pkg::CH_PLUS && seen_reg)
                    begin
                        cmd.count  = 2'd1;
                        cmd.res[0] = upd_pkg::char_res(upd_pkg::CH_SPACE);
                    end
                    else if (in_byte != upd_pkg::CH_PERCENT)
                    begin
                        cmd.count  = 2'd1;
                        cmd.res[0] = upd_pkg::char_res(in_byte);
                    end
                end
            endcase
        end
    end

    assign cmd_push = accept && (cmd.count != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= upd_pkg::PH_IDLE;
            seen_reg    <= 1'b0;
            discard_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            seen_reg    <= seen_next;
            discard_reg <= discard_next;
        end
    end

    // The first digit is only read after it has been written.
    always_ff @(posedge clk)
    begin
        first_reg <= first_next;
    end

endmodule

// File: sv/upd_cmd_fifo.sv
// Command queue between the front and back ends of the URL percent decoder.
// Show-ahead register queue of Depth entries. Uses upd_pkg.
module upd_cmd_fifo
#(
    parameter int unsigned Depth = upd_pkg::CMD_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  upd_pkg::cmd_t wr_cmd,
    output logic          full,
    input  logic          rd_en,
    output upd_pkg::cmd_t rd_cmd,
    output logic          rd_valid
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    upd_pkg::cmd_t   mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_wr;
    logic            do_rd;

    assign full     = (count_reg == CntFull);
    assign rd_valid = (count_reg != '0);
    assign rd_cmd   = mem[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_cmd;
    end

endmodule

// File: sv/upd_back.sv
// Back end of the URL percent decoder: unpacks queued commands into single
// results and holds the oldest one in the output register. Uses upd_pkg.
module upd_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  upd_pkg::cmd_t head_cmd,
    input  logic          head_valid,
    output logic          head_pop,
    output logic          empty,
    input  logic          pop,
    output logic [7:0]    out_byte,
    output logic          has_byte,
    output logic          last
);

    upd_pkg::res_t       out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    upd_pkg::res_t [2:0] cur_res_reg, cur_res_next;
    logic [1:0]          left_reg, left_next;
    logic                advance;

    assign empty   = !out_valid_reg;
    assign advance = !out_valid_reg || pop;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        cur_res_next   = cur_res_reg;
        left_next      = left_reg;
        head_pop       = 1'b0;
        if (advance)
        begin
            if (left_reg != 2'd0)
            begin
                out_next       = cur_res_reg[0];
                out_valid_next = 1'b1;
                cur_res_next   = {upd_pkg::RES_NONE, cur_res_reg[2], cur_res_reg[1]};
                left_next      = left_reg - 2'd1;
            end
            else if (head_valid)
            begin
                out_next       = head_cmd.res[0];
                out_valid_next = 1'b1;
                cur_res_next   = {upd_pkg::RES_NONE, head_cmd.res[2], head_cmd.res[1]};
                left_next      = head_cmd.count - 2'd1;
                head_pop       = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            left_reg      <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            left_reg      <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        cur_res_reg <= cur_res_next;
    end

    assign out_byte = out_reg.data;
    assign has_byte = out_reg.has_byte;
    assign last     = out_reg.last;

endmodule

// File: sv/url_percent_decoder.sv
// URL percent decoder, top level. A result reaches the outputs through the queue, written
// when the byte that caused it is transferred, and then the output register, when the back
// end is free. Throughput: one input byte per cycle while the queue is not full; the back
// end gives one result per cycle while pop is high, so a byte causing two or three results
// (string end after a '%') holds the back end that long.
// Reset (rst_n low, asynchronous) empties the queue and output register and clears all
// escape and string state.
module url_percent_decoder
#(
    parameter int unsigned CmdDepth = upd_pkg::CMD_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       has_byte,
    output logic       last
);

    // The front end works on every transferred byte in the cycle it arrives. Bytes that
    // cause no result (a '%', the digit after it, bytes dropped after a whitespace end)
    // never enter the queue, so they cost nothing in the back end.
    logic          accept;
    logic          cmd_push;
    upd_pkg::cmd_t cmd;
    logic          cmd_full;

    // Queue head as seen by the back end.
    upd_pkg::cmd_t head_cmd;
    logic          head_valid;
    logic          head_pop;

    // Input stalls only when the command queue is full. The queue only fills when the
    // back end is slowed by pop staying low or by a multi-result command.
    assign full   = cmd_full;
    assign accept = push && !cmd_full;

    upd_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .in_byte  (in_byte),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    upd_cmd_fifo
    #(
        .Depth (CmdDepth)
    )
    u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_cmd   (cmd),
        .full     (cmd_full),
        .rd_en    (head_pop),
        .rd_cmd   (head_cmd),
        .rd_valid (head_valid)
    );

    // The back end keeps a result in its output register while the consumer stalls and refills
    // it in the same cycle as a transfer, so results stream at one per cycle while pop is high.
    upd_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .empty      (empty),
        .pop        (pop),
        .out_byte   (out_byte),
        .has_byte   (has_byte),
        .last       (last)
    );

endmodule

// File: sv/upd_checker.sv
// Port-level checks for the URL percent decoder, bound to the top level.
// Depends on url_percent_decoder_macros.svh.
`include "url_percent_decoder_macros.svh"

module upd_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       empty,
    input logic       pop,
    input logic [7:0] out_byte,
    input logic       has_byte,
    input logic       last
);

    // A waiting result stays put until it is transferred.
    `UPD_ASSERT_NEXT(a_result_hold, clk, rst_n, (!empty && !pop), (!empty && $stable(out_byte) && $stable(has_byte) && $stable(last)))

    // The end marker carries no character.
    `UPD_ASSERT_IMP(a_marker_clean, clk, rst_n, (!empty && last), (out_byte == 8'h00 && !has_byte))

    // Every result is either a character or the end marker, never both or neither.
    `UPD_ASSERT_IMP(a_result_kind, clk, rst_n, (!empty), (has_byte != last))

endmodule

bind url_percent_decoder upd_checker u_upd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .has_byte (has_byte),
    .last     (last)
);

// File: tb/url_percent_decoder_checker.sv
// Checker for the URL percent decoder: watches the byte and result transfers, predicts the
// decoded results and compares them in order. Depends on upd_pkg for the phase type and the
// character constants.
module url_percent_decoder_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  logic       full,
    input  logic [7:0] in_byte,
    input  logic       empty,
    input  logic       pop,
    input  logic [7:0] out_byte,
    input  logic       has_byte,
    input  logic       last,
    output int         fail_count,
    output int         outstanding
);

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       fin;
    } decoded_t;

    decoded_t        decoded_q[$];
    upd_pkg::phase_t esc_phase   = upd_pkg::PH_IDLE;
    logic [7:0]      held_digit  = 8'h00;
    logic            pct_seen    = 1'b0;
    logic            draining    = 1'b0;
    int              fails       = 0;
    int              waiting     = 0;

    assign fail_count  = fails;
    assign outstanding = waiting;

    function automatic logic ws_byte(input logic [7:0] b);
        ws_byte = (b >= 8'h09 && b <= 8'h0D) || b == upd_pkg::CH_SPACE;
    endfunction

    // Letters and other bytes above '9' weigh nine more, but only below 0x80.
    function automatic logic [7:0] nibble_weight(input logic [7:0] b);
        nibble_weight = {4'h0, b[3:0]} + ((b > upd_pkg::CH_NINE && b < 8'h80) ? 8'd9 : 8'd0);
    endfunction

    function automatic decoded_t text_char(input logic [7:0] b);
        text_char = '{ch: b, has: 1'b1, fin: 1'b0};
    endfunction

    task automatic expect_char(input decoded_t d);
        decoded_q.push_back(d);
    endtask

    task automatic end_string();
        decoded_q.push_back('{ch: 8'h00, has: 1'b0, fin: 1'b1});
        esc_phase  = upd_pkg::PH_IDLE;
        held_digit = 8'h00;
        pct_seen   = 1'b0;
        draining   = 1'b0;
    endtask

    // A plain byte outside any escape; also used for the byte left pending when the
    // string ends right after it.
    task automatic plain_byte(input logic [7:0] b);
        if (b == upd_pkg::CH_PLUS && pct_seen)
            expect_char(text_char(upd_pkg::CH_SPACE));
        else
            expect_char(text_char(b));
    endtask

    task automatic decode_byte(input logic [7:0] b);
        if (draining) begin
            if (b == upd_pkg::CH_NUL)
            begin
                draining = 1'b0;
                pct_seen = 1'b0;
            end
        end
        else if (esc_phase == upd_pkg::PH_PCT) begin
            if (b == upd_pkg::CH_NUL)
            begin
                expect_char(text_char(upd_pkg::CH_PERCENT));
                end_string();
            end
            else
            begin
                held_digit = b;
                esc_phase  = upd_pkg::PH_DIGIT;
            end
        end
        else if (esc_phase == upd_pkg::PH_DIGIT) begin
            if (b == upd_pkg::CH_NUL)
            begin
                expect_char(text_char(upd_pkg::CH_PERCENT));
                if (!ws_byte(held_digit))
                    plain_byte(held_digit);
                end_string();
            end
            else
            begin
                expect_char(text_char((nibble_weight(held_digit) << 4) + nibble_weight(b)));
                esc_phase  = upd_pkg::PH_IDLE;
                held_digit = 8'h00;
            end
        end
        else if (b == upd_pkg::CH_NUL) begin
            end_string();
        end
        else if (ws_byte(b)) begin
            end_string();
            draining = 1'b1;
        end
        else if (b == upd_pkg::CH_PERCENT) begin
            pct_seen  = 1'b1;
            esc_phase = upd_pkg::PH_PCT;
        end
        else begin
            plain_byte(b);
        end
    endtask

    task automatic report(input decoded_t want, input decoded_t got, input logic orphan);
        fails++;
        if (fails <= REPORT_LIMIT) begin
            if (orphan)
                $display("unexpected result: byte=%02h has=%0b last=%0b",
                         got.ch, got.has, got.fin);
            else
                $display("mismatch: expected byte=%02h has=%0b last=%0b, got byte=%02h has=%0b last=%0b",
                         want.ch, want.has, want.fin, got.ch, got.has, got.fin);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        decoded_t got;
        decoded_t want;
        if (!rst_n) begin
            decoded_q.delete();
            esc_phase  = upd_pkg::PH_IDLE;
            held_digit = 8'h00;
            pct_seen   = 1'b0;
            draining   = 1'b0;
            waiting    = 0;
        end
        else begin
            if (push && !full)
                decode_byte(in_byte);
            if (pop && !empty) begin
                got = '{ch: out_byte, has: has_byte, fin: last};
                if (decoded_q.size() == 0)
                    report(got, got, 1'b1);
                else begin
                    want = decoded_q.pop_front();
                    if (got !== want)
                        report(want, got, 1'b0);
                end
            end
            waiting = decoded_q.size();
        end
    end

endmodule

// File: tb/tb.sv
// Top of the URL percent decoder testbench: clock, reset, byte and result stimulus with
// random idling, watchdog and verdict. Depends on upd_pkg, url_percent_decoder and
// url_percent_decoder_checker.
module tb;

    // Bytes that go in before the random part. Each group is one string: a plain
    // character, '+' before and after the first escape, a zero right after '%',
    // a '+' and a blank left pending when the string ends after '%', high bytes as
    // digits (no letter adjustment), '%' as the pending byte, and a whitespace end
    // whose trailing bytes must be dropped.
    localparam int DIRECTED_LEN = 27;
    localparam logic [7:0] DIRECTED [DIRECTED_LEN] = '{
        "A", upd_pkg::CH_NUL,
        upd_pkg::CH_PLUS, upd_pkg::CH_PERCENT, "4", "1", upd_pkg::CH_PLUS, upd_pkg::CH_NUL,
        upd_pkg::CH_PERCENT, upd_pkg::CH_NUL,
        upd_pkg::CH_PERCENT, upd_pkg::CH_PLUS, upd_pkg::CH_NUL,
        upd_pkg::CH_PERCENT, upd_pkg::CH_SPACE, upd_pkg::CH_NUL,
        upd_pkg::CH_PERCENT, 8'hFF, 8'h80, upd_pkg::CH_NUL,
        upd_pkg::CH_PERCENT, upd_pkg::CH_PERCENT, upd_pkg::CH_NUL,
        "z", upd_pkg::CH_SPACE, "q", upd_pkg::CH_NUL
    };
    localparam int RANDOM_ITEMS   = 250;
    localparam int CALM_AFTER     = DIRECTED_LEN + (RANDOM_ITEMS * 4) / 5;
    localparam int WATCHDOG_LIMIT = 500;
    localparam int DRAIN_CYCLES   = 8;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       push     = 1'b0;
    logic [7:0] in_byte  = 8'h00;
    logic       pop      = 1'b0;
    logic       full;
    logic       empty;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       last;
    int         fail_count;
    int         outstanding;

    // Once set, neither side idles any more.
    logic       calm      = 1'b0;
    int         bytes_sent = 0;
    int         idle_cycles = 0;

    url_percent_decoder dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_byte  (in_byte),
        .empty    (empty),
        .pop      (pop),
        .out_byte (out_byte),
        .has_byte (has_byte),
        .last     (last)
    );

    url_percent_decoder_checker checker_i
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .in_byte     (in_byte),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .has_byte    (has_byte),
        .last        (last),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Offers one byte and holds it until the decoder takes it. Push is never lowered
    // between back-to-back bytes; an idle burst lowers it first and raises it again
    // only at a later falling edge, so each time step sees at most one update of push.
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        push    <= 1'b1;
        in_byte <= b;
        do
            @(posedge clk);
        while (full);
        bytes_sent++;
        if (bytes_sent >= CALM_AFTER)
            calm = 1'b1;
        @(negedge clk);
    endtask

    function automatic logic [7:0] hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(0, 15));
        if (v < 4'd10)
            hex_char = "0" + {4'h0, v};
        else if ($urandom_range(0, 1) == 0)
            hex_char = "a" + {4'h0, v} - 8'd10;
        else
            hex_char = "A" + {4'h0, v} - 8'd10;
    endfunction

    // One byte of a URI body. Most are ordinary characters; the rest are the bytes
    // that steer the decoder: '%', '+', whitespace, high bytes and anything at all
    // (a zero among them ends the string early).
    function automatic logic [7:0] uri_byte();
        logic [7:0] b;
        case ($urandom_range(0, 11))
            0:       b = upd_pkg::CH_PERCENT;
            1:       b = upd_pkg::CH_PLUS;
            2:       b = ($urandom_range(0, 2) == 0) ? upd_pkg::CH_SPACE
                                                     : 8'($urandom_range(9, 13));
            3:       b = 8'($urandom_range(128, 255));
            4, 5:    b = hex_char();
            6:       b = 8'($urandom_range(0, 255));
            default: b = 8'($urandom_range(33, 126));
        endcase
        uri_byte = b;
    endfunction

    // Result side: pop is held high except during random stall bursts, and the
    // stalls stop once the run has gone calm.
    initial
    begin
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (calm)
                pop <= 1'b1;
            else if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                pop <= 1'b0;
                stall_left = $urandom_range(1, 19) - 1;
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog: counts cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        int len;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_LEN; i++)
            send_byte(DIRECTED[i]);

        // Random strings: a mix of well-formed escapes and loose bytes, each closed by
        // a zero. Whitespace inside a string ends it early and sends the rest of the
        // string through the drop path; an escape near the end gets cut by the zero.
        while (bytes_sent < DIRECTED_LEN + RANDOM_ITEMS)
        begin
            len = $urandom_range(0, 10);
            for (int k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    send_byte(upd_pkg::CH_PERCENT);
                    send_byte(hex_char());
                    send_byte(hex_char());
                end
                else
                    send_byte(uri_byte());
            end
            send_byte(upd_pkg::CH_NUL);
        end
        push <= 1'b0;

        // Let every expected result drain, then give the pipeline time to show any
        // result that should not be there.
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
